@@ rtl/als_pkg.sv @@
// Shared types and constants for the adjacency list symmetrize block.
// No dependencies; als_ctrl, als_dp and the top level import this package.
package als_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_ENTRIES  = 1024;

  localparam int VW       = 6;                         // vertex field width
  localparam int NW       = VW + 1;                    // vertex count width
  localparam int NSLOTS   = 2 ** VW;                   // mask bits
  localparam int EW       = $clog2(MAX_ENTRIES);       // entry address width
  localparam int CW       = $clog2(MAX_ENTRIES + 1);   // entry count width
  localparam int RAM_W    = 2 * VW;                    // owner and neighbor
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_SWEEP  = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic idle;
    logic scan;
    logic sweep;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic qry_go;
    logic scan_done;
    logic sweep_done;
    logic fin_ok;
  } sts_t;

endpackage

@@ rtl/als_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module als_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/als_ctrl.sv @@
// Query sequencer: idle, scan the entry store, sweep the incoming mask, finish.
// Depends on als_pkg for the state, command and status types.
module als_ctrl
  import als_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.qry_go) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.fin_ok) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/als_dp.sv @@
// Datapath: entry store, entry count, vertex masks, pending result and output register.
// Depends on als_pkg and als_ram.
module als_dp
  import als_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_wr_en,
  input  logic [NW-1:0]     cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  logic [NW-1:0]     vcnt_r, vcnt_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic              d_vld_r, d_vld_nxt;
  logic [VW-1:0]     qv_r, qv_nxt;
  logic [NSLOTS-1:0] emit_mask_r, emit_mask_nxt;
  logic [NSLOTS-1:0] in_mask_r, in_mask_nxt;
  logic [NW-1:0]     sweep_r, sweep_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [VW-1:0]     pend_v_r, pend_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VW-1:0]     out_v_r, out_v_nxt;
  logic              out_rv_r, out_rv_nxt;
  logic              out_last_r, out_last_nxt;
  status_t           out_st_r, out_st_nxt;

  logic [NW-1:0]    n_eff;
  logic             out_free, in_acc;
  op_t              op;
  logic [VW-1:0]    in_owner, in_nbr, in_q;
  logic             ram_wr_en, ram_rd_en;
  logic [RAM_W-1:0] ram_rd_data;
  logic [VW-1:0]    e_own, e_nbr, sw_v, hit_v;
  logic             s_ok, s_hit, s_in, w_live, w_hit, hit, stall;

  // Clamp the vertex count register to 1..MAX_VERTICES.
  always_comb begin
    if (vcnt_r == '0) begin
      n_eff = NW'(1);
    end else if (vcnt_r > NW'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = vcnt_r;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = cmd.idle && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);
  assign in_owner  = in_tdata[VW-1:0];
  assign in_nbr    = in_tdata[2*VW-1:VW];
  assign in_q      = in_tdata[3*VW-1:2*VW];

  assign ram_wr_en = in_acc && (op == OP_LOAD) && ({1'b0, in_owner} < n_eff)
                     && ({1'b0, in_nbr} < n_eff) && (cnt_r != CW'(MAX_ENTRIES));

  als_ram #(.W(RAM_W), .D(MAX_ENTRIES)) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cnt_r[EW-1:0]),
    .wr_data ({in_nbr, in_owner}),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_cnt_r[EW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign e_own  = ram_rd_data[VW-1:0];
  assign e_nbr  = ram_rd_data[2*VW-1:VW];
  assign s_ok   = d_vld_r && ({1'b0, e_own} < n_eff) && ({1'b0, e_nbr} < n_eff);
  assign s_hit  = cmd.scan && s_ok && (e_own == qv_r) && !emit_mask_r[e_nbr];
  assign s_in   = cmd.scan && s_ok && (e_nbr == qv_r);
  assign sw_v   = sweep_r[VW-1:0];
  assign w_live = cmd.sweep && (sweep_r != n_eff);
  assign w_hit  = w_live && in_mask_r[sw_v] && !emit_mask_r[sw_v];
  assign hit    = s_hit || w_hit;
  assign hit_v  = s_hit ? e_nbr : sw_v;
  // Hold the walk when a found vertex must push the pending one out and the output is busy.
  assign stall  = hit && pend_vld_r && !out_free;

  always_comb begin
    vcnt_nxt      = vcnt_r;
    cnt_nxt       = cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    d_vld_nxt     = d_vld_r;
    qv_nxt        = qv_r;
    emit_mask_nxt = emit_mask_r;
    in_mask_nxt   = in_mask_r;
    sweep_nxt     = sweep_r;
    pend_vld_nxt  = pend_vld_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_v_nxt     = out_v_r;
    out_rv_nxt    = out_rv_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    ram_rd_en     = 1'b0;
    sts           = '0;

    if (cfg_wr_en) vcnt_nxt = cfg_wr_data;

    if (in_acc) begin
      out_v_nxt    = '0;
      out_rv_nxt   = 1'b0;
      out_last_nxt = 1'b1;
      out_st_nxt   = ST_OK;
      case (op)
        OP_LOAD: begin
          out_valid_nxt = 1'b1;
          if (({1'b0, in_owner} >= n_eff) || ({1'b0, in_nbr} >= n_eff)) begin
            out_st_nxt = ST_RANGE;
          end else if (cnt_r == CW'(MAX_ENTRIES)) begin
            out_st_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        OP_CLEAR: begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = '0;
        end
        OP_QUERY: begin
          if ({1'b0, in_q} >= n_eff) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_RANGE;
          end else begin
            sts.qry_go    = 1'b1;
            qv_nxt        = in_q;
            emit_mask_nxt = '0;
            in_mask_nxt   = '0;
            rd_cnt_nxt    = '0;
            d_vld_nxt     = 1'b0;
            sweep_nxt     = '0;
            pend_vld_nxt  = 1'b0;
          end
        end
        default: begin
          out_valid_nxt = 1'b1;
        end
      endcase
    end

    if (cmd.scan) begin
      sts.scan_done = !d_vld_r && (rd_cnt_r == cnt_r);
      if (!stall) begin
        if (s_hit) emit_mask_nxt[e_nbr] = 1'b1;
        if (s_in)  in_mask_nxt[e_own]   = 1'b1;
        if (rd_cnt_r != cnt_r) begin
          ram_rd_en  = 1'b1;
          rd_cnt_nxt = rd_cnt_r + 1'b1;
          d_vld_nxt  = 1'b1;
        end else begin
          d_vld_nxt = 1'b0;
        end
      end
    end

    if (cmd.sweep) begin
      sts.sweep_done = !w_live;
      if (w_live && !stall) sweep_nxt = sweep_r + 1'b1;
    end

    if (hit && !stall) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_v_nxt     = pend_v_r;
        out_rv_nxt    = 1'b1;
        out_last_nxt  = 1'b0;
        out_st_nxt    = ST_OK;
      end
      pend_vld_nxt = 1'b1;
      pend_v_nxt   = hit_v;
    end

    // Close the run: the pending vertex goes out as last, or an empty result.
    if (cmd.finish) begin
      sts.fin_ok = out_free;
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_v_nxt     = pend_vld_r ? pend_v_r : '0;
        out_rv_nxt    = pend_vld_r;
        out_last_nxt  = 1'b1;
        out_st_nxt    = ST_OK;
        pend_vld_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= NW'(MAX_VERTICES);
      cnt_r       <= '0;
      rd_cnt_r    <= '0;
      d_vld_r     <= 1'b0;
      emit_mask_r <= '0;
      in_mask_r   <= '0;
      sweep_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      cnt_r       <= cnt_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      d_vld_r     <= d_vld_nxt;
      emit_mask_r <= emit_mask_nxt;
      in_mask_r   <= in_mask_nxt;
      sweep_r     <= sweep_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qv_r       <= qv_nxt;
    pend_v_r   <= pend_v_nxt;
    out_v_r    <= out_v_nxt;
    out_rv_r   <= out_rv_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_v_r);
  assign out_tuser  = {out_st_r, out_rv_r};
  assign out_tlast  = out_last_r;

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idle |-> !pend_vld_r)
    else $error("pending result left over while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> rd_cnt_r <= cnt_r)
    else $error("scan read past entry count");

  a_single_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op != OP_QUERY) |=> out_valid_r && out_last_r && !out_rv_r)
    else $error("single-result request gave no acknowledge");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rv_r |-> out_last_r)
    else $error("result without vertex not marked last");

endmodule

@@ rtl/adjacency_list_symmetrize.sv @@
// Top level of the adjacency list symmetrize block: controller plus datapath.
// Depends on als_pkg, als_ctrl, als_dp (which holds als_ram).
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready  | tuser op, tdata owner/neighbor/query
//  out_    | master    | out_tvalid / out_tready| tdata vertex, tuser valid/status, tlast
//  cfg_    | write     | cfg_wr_en              | cfg_wr_data vertex count
//
// Load, clear and unused requests each give one acknowledge.
// A query keeps in_tready low once it is accepted until its run is finished: one stored
// entry per cycle through the entry RAM read port, then one vertex per cycle over the masks,
// each only while the walk is not held by a busy output, then the last result.
// Reset is synchronous; the entry store has no clearing pass and is usable at once.
// A busy output register holds the walk whenever a found vertex has to be pushed.
module adjacency_list_symmetrize
  import als_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NW-1:0]     cfg_wr_data,  // vertex_count
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,     // list_owner[5:0], neighbor[11:6], query_vertex[17:12]
  input  logic [1:0]        in_tuser,     // operation[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,    // result_vertex[5:0]
  output logic [2:0]        out_tuser,    // result_valid[0], status[2:1]
  output logic              out_tlast     // last_of_run
);

  cmd_t cmd;
  sts_t sts;

  als_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  als_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
